@@ design/rcm_pkg.sv @@
// rcm_pkg: shared types and constants for the per-character RSA exponentiation block.
// Holds the beat payload structs, the datapath width and the CSR register indexes.
// No dependencies.
`timescale 1ns / 1ps

package rcm_pkg;

   // Datapath width of modulus, exponents and values
   localparam int MOD_WIDTH = 16;
   localparam int CNT_WIDTH = $clog2(MOD_WIDTH);

   // CSR register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS          = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PUBLIC_EXPONENT  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRIVATE_EXPONENT = 2'd2;

   // CSR reset values
   localparam logic [MOD_WIDTH-1:0] MODULUS_RESET          = MOD_WIDTH'(3233);
   localparam logic [MOD_WIDTH-1:0] PUBLIC_EXPONENT_RESET  = MOD_WIDTH'(17);
   localparam logic [MOD_WIDTH-1:0] PRIVATE_EXPONENT_RESET = MOD_WIDTH'(2753);

   // Command codes
   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   typedef struct packed {
      logic                 command;
      logic [MOD_WIDTH-1:0] value;
      logic                 last_in;
   } req_payload_type;

   typedef struct packed {
      logic [MOD_WIDTH-1:0] result;
      logic                 last_out;
   } rsp_payload_type;

endpackage

@@ design/rsa_char_modexp.sv @@
// rsa_char_modexp: per-character RSA modular exponentiation, bit-serial datapath.
// Depends on rcm_pkg for payload structs, widths and CSR indexes.
`timescale 1ns / 1ps

// Usage:
//   req channel: one beat carries command (0 encrypt, 1 decrypt), value and
//   last_in. The block takes a beat only when idle; req_stall is high while
//   an item is in work.
//   rsp channel: one beat per request with result = value^exponent mod modulus
//   and last_out copied from last_in. A modulus of zero gives result 0.
//   csr port: csr_we with csr_index 0 (modulus), 1 (public exponent) or
//   2 (private exponent); other indexes are ignored. Write only while idle.
// Timing: the value is first reduced one bit per cycle, then every exponent
//   bit costs one modular squaring and, if the bit is set, one modular
//   multiply; each goes through the shared shift-and-add unit. Items run
//   one at a time; the next is taken after the result is handed off.
// Reset: synchronous, active high; clears the sequencer and the output
//   valid and restores modulus 3233, exponents 17 and 2753.
// Stall: a held rsp beat stays put; a finished result waits in the sequencer
//   until the output register frees, and no new request is taken meanwhile.
module rsa_char_modexp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  rcm_pkg::req_payload_type              req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output rcm_pkg::rsp_payload_type              rsp_payload,
   input  logic                                  csr_we,
   input  logic [rcm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [rcm_pkg::MOD_WIDTH-1:0]         csr_wdata
);
   import rcm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REDUCE,
      S_SQUARE,
      S_MULT,
      S_FINISH
   } state_type;

   localparam int MSB = MOD_WIDTH - 1;
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(MOD_WIDTH - 1);

   state_type            state_ff, state_in;
   logic [MSB:0]         mod_ff, pub_exp_ff, priv_exp_ff;
   logic [MSB:0]         acc_ff, acc_in;
   logic [MSB:0]         base_ff, base_in;
   logic [MSB:0]         prod_ff, prod_in;
   logic [MSB:0]         mplr_ff, mplr_in;
   logic [MSB:0]         exp_ff, exp_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [CNT_WIDTH-1:0] ecnt_ff, ecnt_in;
   logic                 last_ff, last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_payload_ff, rsp_payload_in;

   logic                 req_accept;
   logic                 shift_bit;
   logic [MSB:0]         mcand;
   logic [MOD_WIDTH:0]   dbl, sum, mod_ext;
   logic [MSB:0]         red1, red2, step_res;

   assign req_accept = req_valid && (state_ff == S_IDLE);
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Shared step: double plus incoming bit, reduce; then add multiplicand, reduce
   assign mod_ext   = {1'b0, mod_ff};
   assign shift_bit = (state_ff == S_REDUCE) ? mplr_ff[MSB] : 1'b0;
   assign mcand     = (state_ff == S_MULT) ? base_ff : acc_ff;
   assign dbl       = {prod_ff, shift_bit};
   assign red1      = (dbl >= mod_ext) ? MOD_WIDTH'(dbl - mod_ext) : dbl[MSB:0];
   assign sum       = {1'b0, red1} + {1'b0, mcand};
   assign red2      = (sum >= mod_ext) ? MOD_WIDTH'(sum - mod_ext) : sum[MSB:0];
   assign step_res  = ((state_ff != S_REDUCE) && mplr_ff[MSB]) ? red2 : red1;

   // Sequencer and datapath next values
   always_comb begin
      state_in       = state_ff;
      acc_in         = acc_ff;
      base_in        = base_ff;
      prod_in        = prod_ff;
      mplr_in        = mplr_ff;
      exp_in         = exp_ff;
      cnt_in         = cnt_ff;
      ecnt_in        = ecnt_ff;
      last_in        = last_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               mplr_in     = req_payload.value;
               prod_in     = '0;
               cnt_in      = CNT_LAST;
               ecnt_in     = CNT_LAST;
               exp_in      = (req_payload.command == CMD_DECRYPT) ? priv_exp_ff : pub_exp_ff;
               last_in     = req_payload.last_in;
               acc_in      = (mod_ff == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
               state_in    = S_REDUCE;
            end
         end
         S_REDUCE: begin
            prod_in = step_res;
            mplr_in = mplr_ff << 1;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               // Reduced value becomes the base; start squaring the accumulator
               base_in  = step_res;
               mplr_in  = acc_ff;
               prod_in  = '0;
               cnt_in   = CNT_LAST;
               state_in = S_SQUARE;
            end
         end
         S_SQUARE, S_MULT: begin
            prod_in = step_res;
            mplr_in = mplr_ff << 1;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               acc_in  = step_res;
               mplr_in = step_res;
               prod_in = '0;
               cnt_in  = CNT_LAST;
               if ((state_ff == S_SQUARE) && exp_ff[MSB]) begin
                  state_in = S_MULT;
               end else begin
                  // Advance to the next exponent bit
                  exp_in = exp_ff << 1;
                  if (ecnt_ff == '0) begin
                     state_in = S_FINISH;
                  end else begin
                     ecnt_in  = ecnt_ff - 1'b1;
                     state_in = S_SQUARE;
                  end
               end
            end
         end
         S_FINISH: begin
            // Hand off once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_payload_in.result   = (mod_ff == '0) ? '0 : acc_ff;
               rsp_payload_in.last_out = last_ff;
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, CSRs and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mod_ff       <= MODULUS_RESET;
         pub_exp_ff   <= PUBLIC_EXPONENT_RESET;
         priv_exp_ff  <= PRIVATE_EXPONENT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MODULUS:          mod_ff      <= csr_wdata;
               CSR_PUBLIC_EXPONENT:  pub_exp_ff  <= csr_wdata;
               CSR_PRIVATE_EXPONENT: priv_exp_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      acc_ff         <= acc_in;
      base_ff        <= base_in;
      prod_ff        <= prod_in;
      mplr_ff        <= mplr_in;
      exp_ff         <= exp_in;
      cnt_ff         <= cnt_in;
      ecnt_ff        <= ecnt_in;
      last_ff        <= last_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // An accepted request always starts with the reduction pass
   a_accept_reduce: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_REDUCE))
      else $error("accepted request did not enter reduction");

   // Reduction hands over to squaring after its last bit
   a_reduce_to_square: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REDUCE) && (cnt_ff == '0) |=> (state_ff == S_SQUARE))
      else $error("reduction did not hand over to squaring");

   // A new result beat only comes from the finish step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("result beat raised outside finish step");

   // A finished result waits while the output register is blocked
   a_finish_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) && rsp_valid_ff && rsp_stall |=> (state_ff == S_FINISH))
      else $error("finished result left while output was stalled");

endmodule
